@@ design/cetq_pkg.sv @@
`default_nettype none

package cetq_pkg;

   localparam int NORMAL_DEPTH  = 64;
   localparam int PRIOR_DEPTH   = 16;
   localparam int PAYLOAD_WIDTH = 64;
   localparam int KEY_WIDTH     = 32;

   localparam int KEY_W   = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
   localparam int PAY_W   = (PAYLOAD_WIDTH < 64) ? PAYLOAD_WIDTH : 64;
   localparam int NPTR_W  = $clog2(NORMAL_DEPTH);
   localparam int NCNT_W  = $clog2(NORMAL_DEPTH + 1);
   localparam int PPTR_W  = $clog2(PRIOR_DEPTH);
   localparam int PCNT_W  = $clog2(PRIOR_DEPTH + 1);
   localparam int OUT_CNT_W = 7;

   typedef enum logic [1:0] {
      OP_PUSH      = 2'd0,
      OP_PRIO_PUSH = 2'd1,
      OP_POP       = 2'd2,
      OP_FLUSH     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NORMAL_FULL = 3'd1,
      ST_ZERO_KEY    = 3'd2,
      ST_PRIOR_FULL  = 3'd3,
      ST_POP_EMPTY   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] event_key;
      logic [63:0] event_payload;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic                   popped_valid;
      logic [63:0]            popped_payload;
      logic [OUT_CNT_W-1:0]   pending_count;
      logic [OUT_CNT_W-1:0]   high_water;
   } rsp_type;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic             flush;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } plist_ctrl_type;

   typedef struct packed {
      logic              hit;
      logic [PCNT_W-1:0] count;
      logic [PAY_W-1:0]  head_payload;
   } plist_stat_type;

endpackage

`default_nettype wire

@@ design/cetq_plist.sv @@
`default_nettype none

module cetq_plist (
   input  wire                       clock,
   input  wire                       reset,
   input  wire cetq_pkg::plist_ctrl_type ctrl,
   output cetq_pkg::plist_stat_type  stat
);

   localparam int OFF_W = cetq_pkg::PPTR_W + 1;
   localparam logic [OFF_W-1:0] PD = OFF_W'(cetq_pkg::PRIOR_DEPTH);

   logic [cetq_pkg::PAY_W-1:0]  pay_mem [cetq_pkg::PRIOR_DEPTH];
   logic [cetq_pkg::KEY_W-1:0]  key_ff  [cetq_pkg::PRIOR_DEPTH];
   logic [cetq_pkg::PAY_W-1:0]  head_rd_ff;

   logic [cetq_pkg::PPTR_W-1:0] head_ff, head_in;
   logic [cetq_pkg::PCNT_W-1:0] count_ff, count_in;

   logic [OFF_W-1:0]                 off [cetq_pkg::PRIOR_DEPTH];
   logic [cetq_pkg::PRIOR_DEPTH-1:0] hit_vec;
   logic [cetq_pkg::PPTR_W-1:0]      hit_idx;
   logic                             hit;
   logic                             full;
   logic [OFF_W-1:0]                 tail_sum;
   logic [cetq_pkg::PPTR_W-1:0]      tail;
   logic                             append;
   logic                             write_en;
   logic [cetq_pkg::PPTR_W-1:0]      write_addr;

   always_comb begin
      hit_idx = '0;
      for (int s = 0; s < cetq_pkg::PRIOR_DEPTH; s++) begin
         if (cetq_pkg::PPTR_W'(s) >= head_ff) begin
            off[s] = OFF_W'(s) - OFF_W'(head_ff);
         end else begin
            off[s] = OFF_W'(s) + PD - OFF_W'(head_ff);
         end
         hit_vec[s] = (off[s] < OFF_W'(count_ff)) && (key_ff[s] == ctrl.key);
         if (hit_vec[s]) begin
            hit_idx = hit_idx | cetq_pkg::PPTR_W'(s);
         end
      end
   end

   assign hit      = |hit_vec;
   assign full     = (count_ff == cetq_pkg::PCNT_W'(cetq_pkg::PRIOR_DEPTH));
   assign tail_sum = OFF_W'(head_ff) + OFF_W'(count_ff);
   assign tail     = (tail_sum >= PD) ? cetq_pkg::PPTR_W'(tail_sum - PD)
                                      : cetq_pkg::PPTR_W'(tail_sum);
   assign append     = ctrl.push && !hit && !full;
   assign write_en   = ctrl.push && (hit || !full);
   assign write_addr = hit ? hit_idx : tail;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctrl.flush) begin
         head_in  = '0;
         count_in = '0;
      end else if (ctrl.pop) begin
         head_in  = (head_ff == cetq_pkg::PPTR_W'(cetq_pkg::PRIOR_DEPTH - 1)) ? '0
                                                                               : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (append) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         pay_mem[write_addr] <= ctrl.payload;
      end
      head_rd_ff <= pay_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (append) begin
         key_ff[tail] <= ctrl.key;
      end
   end

   assign stat.hit          = hit;
   assign stat.count        = count_ff;
   assign stat.head_payload = head_rd_ff;

endmodule

`default_nettype wire

@@ design/coalescing_two_class_event_queue_top.sv @@
// Channel   Ports                     Handshake
// request   start, busy, req_item     taken when start is high and busy is low
// response  rsp_valid, rsp_item       one-cycle strobe, cannot be held off
//
// A request is taken in S_IDLE and run in S_EXEC: the head reads of the FIFO
// memory and the priority payload memory issue at the accept edge, the next
// cycle compares the key against all priority entries and writes back.
// The response strobes in the cycle after that; busy is low then, so the
// next request can be taken in that same cycle.
// Reset is synchronous and empties both queues; no clearing pass is needed.
`default_nettype none

module coalescing_two_class_event_queue_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire cetq_pkg::req_type req_item,
   output logic                rsp_valid,
   output cetq_pkg::rsp_type   rsp_item
);

   localparam int SUM_W = cetq_pkg::NCNT_W + 1;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                    state_ff, state_in;
   cetq_pkg::req_type            req_ff, req_in;
   cetq_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cetq_pkg::NPTR_W-1:0]  nhead_ff, nhead_in;
   logic [cetq_pkg::NPTR_W-1:0]  ntail_ff, ntail_in;
   logic [cetq_pkg::NCNT_W-1:0]  ncount_ff, ncount_in;
   logic [cetq_pkg::NCNT_W-1:0]  peak_ff, peak_in;

   logic [cetq_pkg::PAY_W-1:0]   nmem [cetq_pkg::NORMAL_DEPTH];
   logic [cetq_pkg::PAY_W-1:0]   nrd_ff;
   logic                         nwrite;

   cetq_pkg::plist_ctrl_type     pctrl;
   cetq_pkg::plist_stat_type     pstat;
   logic [cetq_pkg::PCNT_W-1:0]  pcount_after;
   logic [SUM_W-1:0]             pend_sum;
   cetq_pkg::op_type             op;
   logic [cetq_pkg::PAY_W-1:0]   pay;

   cetq_plist u_plist (
      .clock (clock),
      .reset (reset),
      .ctrl  (pctrl),
      .stat  (pstat)
   );

   assign op  = cetq_pkg::op_type'(req_ff.operation);
   assign pay = req_ff.event_payload[cetq_pkg::PAY_W-1:0];

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      nhead_in      = nhead_ff;
      ntail_in      = ntail_ff;
      ncount_in     = ncount_ff;
      peak_in       = peak_ff;
      nwrite        = 1'b0;
      pctrl.push    = 1'b0;
      pctrl.pop     = 1'b0;
      pctrl.flush   = 1'b0;
      pctrl.key     = req_ff.event_key[cetq_pkg::KEY_W-1:0];
      pctrl.payload = pay;
      pcount_after  = pstat.count;
      pend_sum      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in              = S_IDLE;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = cetq_pkg::ST_OK;
            rsp_in.popped_valid   = 1'b0;
            rsp_in.popped_payload = '0;
            unique case (op)
               cetq_pkg::OP_PUSH: begin
                  if (ncount_ff < cetq_pkg::NCNT_W'(cetq_pkg::NORMAL_DEPTH)) begin
                     nwrite    = 1'b1;
                     ntail_in  = (ntail_ff == cetq_pkg::NPTR_W'(cetq_pkg::NORMAL_DEPTH - 1))
                                 ? '0 : ntail_ff + 1'b1;
                     ncount_in = ncount_ff + 1'b1;
                     if (ncount_in > peak_ff) begin
                        peak_in = ncount_in;
                     end
                  end else begin
                     rsp_in.status = cetq_pkg::ST_NORMAL_FULL;
                  end
               end
               cetq_pkg::OP_PRIO_PUSH: begin
                  if (pctrl.key == '0) begin
                     rsp_in.status = cetq_pkg::ST_ZERO_KEY;
                  end else begin
                     pctrl.push = 1'b1;
                     if (!pstat.hit) begin
                        if (pstat.count == cetq_pkg::PCNT_W'(cetq_pkg::PRIOR_DEPTH)) begin
                           rsp_in.status = cetq_pkg::ST_PRIOR_FULL;
                        end else begin
                           pcount_after = pstat.count + 1'b1;
                        end
                     end
                  end
               end
               cetq_pkg::OP_POP: begin
                  if (pstat.count != '0) begin
                     pctrl.pop             = 1'b1;
                     pcount_after          = pstat.count - 1'b1;
                     rsp_in.popped_valid   = 1'b1;
                     rsp_in.popped_payload = 64'(pstat.head_payload);
                  end else if (ncount_ff != '0) begin
                     nhead_in  = (nhead_ff == cetq_pkg::NPTR_W'(cetq_pkg::NORMAL_DEPTH - 1))
                                 ? '0 : nhead_ff + 1'b1;
                     ncount_in = ncount_ff - 1'b1;
                     rsp_in.popped_valid   = 1'b1;
                     rsp_in.popped_payload = 64'(nrd_ff);
                  end else begin
                     rsp_in.status = cetq_pkg::ST_POP_EMPTY;
                  end
               end
               cetq_pkg::OP_FLUSH: begin
                  pctrl.flush  = 1'b1;
                  pcount_after = '0;
                  nhead_in     = '0;
                  ntail_in     = '0;
                  ncount_in    = '0;
               end
               default: begin
               end
            endcase
            pend_sum             = SUM_W'(ncount_in) + SUM_W'(pcount_after);
            rsp_in.pending_count = cetq_pkg::OUT_CNT_W'(pend_sum);
            rsp_in.high_water    = cetq_pkg::OUT_CNT_W'(peak_in);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         nhead_ff     <= '0;
         ntail_ff     <= '0;
         ncount_ff    <= '0;
         peak_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nhead_ff     <= nhead_in;
         ntail_ff     <= ntail_in;
         ncount_ff    <= ncount_in;
         peak_ff      <= peak_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (nwrite) begin
         nmem[ntail_ff] <= pay;
      end
      nrd_ff <= nmem[nhead_ff];
   end

   assign busy      = (state_ff == S_EXEC);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_exec_responds: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("request in progress gave no response");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not enter execution");

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      ncount_ff <= cetq_pkg::NCNT_W'(cetq_pkg::NORMAL_DEPTH))
      else $error("normal queue count exceeds depth");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.popped_valid) |-> (rsp_item.status == cetq_pkg::ST_OK))
      else $error("popped event with error status");
`endif

endmodule

`default_nettype wire
